// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define NPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("npd assertion failed");

// clocked property that also holds across reset
`define NPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("npd assertion failed");

`endif

// ----- hdl/npd_pkg.sv -----
// types and constants of the nearest prototype distance block
package npd_pkg;

    localparam int DIMENSIONS_DEF   = 16;
    localparam int MAX_POSITIVE_DEF = 16;
    localparam int MAX_NEGATIVE_DEF = 256;

    localparam logic [35:0] RESET_CLAMP = 36'd4096;
    localparam logic [19:0] SAD_MAX     = 20'd1048560;
    localparam logic [35:0] SSD_MAX     = 36'd68717379600;

    localparam logic [1:0] OP_LOAD_POS  = 2'd0;
    localparam logic [1:0] OP_LOAD_NEG  = 2'd1;
    localparam logic [1:0] OP_CANDIDATE = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_START,
        S_WALK_POS,
        S_WALK_NEG,
        S_DRAIN
    } t_state;

    // marks one component pair travelling through the distance unit
    typedef struct packed {
        logic valid;
        logic neg;
        logic first;
        logic last;
    } t_pair_tag;

endpackage

// ----- hdl/npd_dist_unit.sv -----
// shared distance unit: abs difference, square, saturating sums, running minima
module npd_dist_unit
    import npd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_init,
    input  logic [35:0]        i_clamp,
    input  t_pair_tag          i_tag,
    input  logic signed [15:0] i_p,
    input  logic signed [15:0] i_c,
    output logic [19:0]        o_best_sad,
    output logic [35:0]        o_best_pos,
    output logic [35:0]        o_best_neg,
    output logic               o_idle
);

    t_pair_tag   r_a_tag;
    logic [15:0] r_a_ad;
    t_pair_tag   r_b_tag;
    logic [15:0] r_b_ad;
    logic [31:0] r_b_sq;
    logic [19:0] r_acc_sad;
    logic [35:0] r_acc_ssd;
    logic        r_c_done;
    logic        r_c_neg;
    logic [19:0] r_best_sad;
    logic [35:0] r_best_pos;
    logic [35:0] r_best_neg;

    logic signed [16:0] w_diff;
    logic signed [16:0] w_neg_diff;
    logic [15:0]        w_ad;
    logic [31:0]        w_sq;
    logic [19:0]        w_sad_base;
    logic [35:0]        w_ssd_base;
    logic [20:0]        w_sad_sum;
    logic [36:0]        w_ssd_sum;
    logic [19:0]        w_sad_sat;
    logic [35:0]        w_ssd_sat;

    always_comb begin
        w_diff     = $signed({i_p[15], i_p}) - $signed({i_c[15], i_c});
        w_neg_diff = -w_diff;
        w_ad       = w_diff[16] ? w_neg_diff[15:0] : w_diff[15:0];
        w_sq       = r_a_ad * r_a_ad;
        w_sad_base = r_b_tag.first ? 20'd0 : r_acc_sad;
        w_ssd_base = r_b_tag.first ? 36'd0 : r_acc_ssd;
        w_sad_sum  = {1'b0, w_sad_base} + 21'(r_b_ad);
        w_ssd_sum  = {1'b0, w_ssd_base} + 37'(r_b_sq);
        w_sad_sat  = (w_sad_sum > 21'(SAD_MAX)) ? SAD_MAX : w_sad_sum[19:0];
        w_ssd_sat  = (w_ssd_sum > 37'(SSD_MAX)) ? SSD_MAX : w_ssd_sum[35:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag  <= '0;
            r_b_tag  <= '0;
            r_c_done <= 1'b0;
        end else begin
            r_a_tag  <= i_tag;
            r_b_tag  <= r_a_tag;
            r_c_done <= r_b_tag.valid && r_b_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ad  <= w_ad;
        r_b_ad  <= r_a_ad;
        r_b_sq  <= w_sq;
        r_c_neg <= r_b_tag.neg;
        if (r_b_tag.valid) begin
            r_acc_sad <= w_sad_sat;
            r_acc_ssd <= w_ssd_sat;
        end
        if (i_init) begin
            r_best_sad <= SAD_MAX;
            r_best_pos <= SSD_MAX;
            r_best_neg <= i_clamp;
        end else if (r_c_done) begin
            if (r_c_neg) begin
                if (r_acc_ssd < r_best_neg) begin
                    r_best_neg <= r_acc_ssd;
                end
            end else begin
                if (r_acc_sad < r_best_sad) begin
                    r_best_sad <= r_acc_sad;
                end
                if (r_acc_ssd < r_best_pos) begin
                    r_best_pos <= r_acc_ssd;
                end
            end
        end
    end

    assign o_best_sad = r_best_sad;
    assign o_best_pos = r_best_pos;
    assign o_best_neg = r_best_neg;
    assign o_idle     = !r_a_tag.valid && !r_b_tag.valid && !r_c_done;

endmodule

// ----- hdl/nearest_prototype_distance.sv -----
// top level: prototype stores, candidate buffer and the walk sequencer
// a load or candidate word ending a vector early zero-fills the rest of that vector
// a final candidate word starts a walk after any fill: init, every positive then every negative
// vector component by component through one shared unit, one memory read a cycle, then drain
// other words leave busy low; the strobe comes as busy falls and cannot be held off
// synchronous reset empties both stores, zeroes the candidate, restores the 4096 clamp
module nearest_prototype_distance
    import npd_pkg::*;
#(
    parameter int DIMENSIONS   = DIMENSIONS_DEF,
    parameter int MAX_POSITIVE = MAX_POSITIVE_DEF,
    parameter int MAX_NEGATIVE = MAX_NEGATIVE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_component_value,
    input  logic               i_last_component,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [35:0]        i_cfg_data,
    output logic               o_valid,
    output logic [19:0]        o_positive_sad,
    output logic [35:0]        o_positive_ssd,
    output logic [35:0]        o_negative_ssd,
    output logic               o_no_positive
);

    localparam int PW     = $clog2(DIMENSIONS + 1);
    localparam int IW     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int PCW    = $clog2(MAX_POSITIVE + 1);
    localparam int NCW    = $clog2(MAX_NEGATIVE + 1);
    localparam int VW     = (PCW > NCW) ? PCW : NCW;
    localparam int PDEPTH = MAX_POSITIVE * DIMENSIONS;
    localparam int NDEPTH = MAX_NEGATIVE * DIMENSIONS;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam int PBW    = $clog2(PDEPTH + 1);
    localparam int NBW    = $clog2(NDEPTH + 1);
    localparam int AW     = (PBW > NBW) ? PBW : NBW;

    logic signed [15:0] pmem [PDEPTH];
    logic signed [15:0] nmem [NDEPTH];
    logic signed [15:0] cmem [DIMENSIONS];

    t_state          r_state, n_state;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PCW-1:0]  r_pcount, n_pcount;
    logic [NCW-1:0]  r_ncount, n_ncount;
    logic [PBW-1:0]  r_pbase, n_pbase;
    logic [NBW-1:0]  r_nbase, n_nbase;
    logic [35:0]     r_clamp;
    logic [PW-1:0]   r_fill_idx, n_fill_idx;
    logic [AW-1:0]   r_fill_addr, n_fill_addr;
    logic [1:0]      r_fill_tgt, n_fill_tgt;
    logic [VW-1:0]   r_walk_vec, n_walk_vec;
    logic [IW-1:0]   r_walk_idx, n_walk_idx;
    logic [AW-1:0]   r_walk_addr, n_walk_addr;
    t_pair_tag       r_rd_tag;
    logic signed [15:0] r_prd, r_nrd, r_crd;
    logic            r_out_valid, n_out_valid;
    logic            r_no_pos, n_no_pos;

    logic               w_p_we, w_n_we, w_c_we;
    logic [PAW-1:0]     w_p_addr;
    logic [NAW-1:0]     w_n_addr;
    logic [IW-1:0]      w_c_addr;
    logic signed [15:0] w_wdata;
    logic               w_tgt_ok;
    logic [AW-1:0]      w_fill_base;
    logic               w_last_idx;
    t_pair_tag          w_issue;
    logic               w_init;
    logic               w_unit_idle;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_pcount    = r_pcount;
        n_ncount    = r_ncount;
        n_pbase     = r_pbase;
        n_nbase     = r_nbase;
        n_fill_idx  = r_fill_idx;
        n_fill_addr = r_fill_addr;
        n_fill_tgt  = r_fill_tgt;
        n_walk_vec  = r_walk_vec;
        n_walk_idx  = r_walk_idx;
        n_walk_addr = r_walk_addr;
        n_out_valid = 1'b0;
        n_no_pos    = r_no_pos;
        w_p_we      = 1'b0;
        w_n_we      = 1'b0;
        w_c_we      = 1'b0;
        w_p_addr    = PAW'(r_pbase + PBW'(r_pos));
        w_n_addr    = NAW'(r_nbase + NBW'(r_pos));
        w_c_addr    = IW'(r_pos);
        w_wdata     = i_component_value;
        w_issue     = '0;
        w_init      = 1'b0;
        w_last_idx  = (r_walk_idx == IW'(DIMENSIONS - 1));

        case (i_operation)
            OP_LOAD_POS:  w_tgt_ok = (r_pcount < PCW'(MAX_POSITIVE));
            OP_LOAD_NEG:  w_tgt_ok = (r_ncount < NCW'(MAX_NEGATIVE));
            OP_CANDIDATE: w_tgt_ok = 1'b1;
            default:      w_tgt_ok = 1'b0;
        endcase
        case (i_operation)
            OP_LOAD_POS: w_fill_base = AW'(r_pbase);
            OP_LOAD_NEG: w_fill_base = AW'(r_nbase);
            default:     w_fill_base = '0;
        endcase

        case (r_state)
            S_IDLE: begin
                if (start && (i_operation != OP_UNUSED)) begin
                    if (w_tgt_ok && (r_pos < PW'(DIMENSIONS))) begin
                        w_p_we = (i_operation == OP_LOAD_POS);
                        w_n_we = (i_operation == OP_LOAD_NEG);
                        w_c_we = (i_operation == OP_CANDIDATE);
                    end
                    if (i_last_component) begin
                        n_pos = '0;
                        if (w_tgt_ok && (i_operation == OP_LOAD_POS)) begin
                            n_pcount = r_pcount + PCW'(1);
                            n_pbase  = r_pbase + PBW'(DIMENSIONS);
                        end
                        if (w_tgt_ok && (i_operation == OP_LOAD_NEG)) begin
                            n_ncount = r_ncount + NCW'(1);
                            n_nbase  = r_nbase + NBW'(DIMENSIONS);
                        end
                        // pad the rest of the vector with zeros
                        if (w_tgt_ok && (r_pos < PW'(DIMENSIONS - 1))) begin
                            n_state     = S_FILL;
                            n_fill_idx  = r_pos + PW'(1);
                            n_fill_addr = w_fill_base + AW'(r_pos) + AW'(1);
                            n_fill_tgt  = i_operation;
                        end else if (i_operation == OP_CANDIDATE) begin
                            n_state = S_START;
                        end
                    end else if (r_pos < PW'(DIMENSIONS)) begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            S_FILL: begin
                w_wdata  = '0;
                w_p_addr = PAW'(r_fill_addr);
                w_n_addr = NAW'(r_fill_addr);
                w_c_addr = IW'(r_fill_idx);
                w_p_we   = (r_fill_tgt == OP_LOAD_POS);
                w_n_we   = (r_fill_tgt == OP_LOAD_NEG);
                w_c_we   = (r_fill_tgt == OP_CANDIDATE);
                if (r_fill_idx == PW'(DIMENSIONS - 1)) begin
                    n_state = (r_fill_tgt == OP_CANDIDATE) ? S_START : S_IDLE;
                end else begin
                    n_fill_idx  = r_fill_idx + PW'(1);
                    n_fill_addr = r_fill_addr + AW'(1);
                end
            end
            S_START: begin
                w_init      = 1'b1;
                n_walk_vec  = '0;
                n_walk_idx  = '0;
                n_walk_addr = '0;
                if (r_pcount != '0) begin
                    n_state = S_WALK_POS;
                end else if (r_ncount != '0) begin
                    n_state = S_WALK_NEG;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_WALK_POS: begin
                w_issue.valid = 1'b1;
                w_issue.neg   = 1'b0;
                w_issue.first = (r_walk_idx == '0);
                w_issue.last  = w_last_idx;
                n_walk_addr   = r_walk_addr + AW'(1);
                n_walk_idx    = r_walk_idx + IW'(1);
                if (w_last_idx) begin
                    n_walk_idx = '0;
                    n_walk_vec = r_walk_vec + VW'(1);
                    if (r_walk_vec == VW'(r_pcount) - VW'(1)) begin
                        n_walk_vec  = '0;
                        n_walk_addr = '0;
                        n_state     = (r_ncount != '0) ? S_WALK_NEG : S_DRAIN;
                    end
                end
            end
            S_WALK_NEG: begin
                w_issue.valid = 1'b1;
                w_issue.neg   = 1'b1;
                w_issue.first = (r_walk_idx == '0);
                w_issue.last  = w_last_idx;
                n_walk_addr   = r_walk_addr + AW'(1);
                n_walk_idx    = r_walk_idx + IW'(1);
                if (w_last_idx) begin
                    n_walk_idx = '0;
                    n_walk_vec = r_walk_vec + VW'(1);
                    if (r_walk_vec == VW'(r_ncount) - VW'(1)) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!r_rd_tag.valid && w_unit_idle) begin
                    n_out_valid = 1'b1;
                    n_no_pos    = (r_pcount == '0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_pcount    <= '0;
            r_ncount    <= '0;
            r_pbase     <= '0;
            r_nbase     <= '0;
            r_clamp     <= RESET_CLAMP;
            r_rd_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_pcount    <= n_pcount;
            r_ncount    <= n_ncount;
            r_pbase     <= n_pbase;
            r_nbase     <= n_nbase;
            r_rd_tag    <= w_issue;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_clamp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_idx  <= n_fill_idx;
        r_fill_addr <= n_fill_addr;
        r_fill_tgt  <= n_fill_tgt;
        r_walk_vec  <= n_walk_vec;
        r_walk_idx  <= n_walk_idx;
        r_walk_addr <= n_walk_addr;
        r_no_pos    <= n_no_pos;
    end

    // positive and negative prototype memories, registered read at the walk address
    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            pmem[w_p_addr] <= w_wdata;
        end
        r_prd <= pmem[PAW'(r_walk_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (w_n_we) begin
            nmem[w_n_addr] <= w_wdata;
        end
        r_nrd <= nmem[NAW'(r_walk_addr)];
    end

    // candidate components left unwritten since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIMENSIONS; i++) begin
                cmem[i] <= '0;
            end
        end else if (w_c_we) begin
            cmem[w_c_addr] <= w_wdata;
        end
        r_crd <= cmem[r_walk_idx];
    end

    npd_dist_unit u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (w_init),
        .i_clamp    (r_clamp),
        .i_tag      (r_rd_tag),
        .i_p        (r_rd_tag.neg ? r_nrd : r_prd),
        .i_c        (r_crd),
        .o_best_sad (o_positive_sad),
        .o_best_pos (o_positive_ssd),
        .o_best_neg (o_negative_ssd),
        .o_idle     (w_unit_idle)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_no_positive = r_no_pos;

endmodule

// ----- hdl/npd_checker.sv -----
// port-level checker for the nearest prototype distance block, bound to the top
`include "assert_macros.svh"

module npd_checker
    import npd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_operation,
    input logic               i_last_component,
    input logic               o_valid,
    input logic [19:0]        o_positive_sad,
    input logic [35:0]        o_positive_ssd,
    input logic               o_no_positive
);

    logic w_cand_last;
    logic w_saturated;

    assign w_cand_last = start && !busy && (i_operation == OP_CANDIDATE) && i_last_component;
    assign w_saturated = (o_positive_sad == SAD_MAX) && (o_positive_ssd == SSD_MAX);

    // a final candidate word always starts a walk
    `NPD_ASSERT(a_candidate_walks, i_clk, i_rst_n, w_cand_last |=> busy)

    // one result word per candidate, shown only as the walk ends
    `NPD_ASSERT(a_strobe_single, i_clk, i_rst_n, o_valid |=> !o_valid)
    `NPD_ASSERT(a_strobe_idle, i_clk, i_rst_n, o_valid |-> !busy)

    // an empty positive store reports saturated distances
    `NPD_ASSERT(a_empty_positive, i_clk, i_rst_n, o_valid && o_no_positive |-> w_saturated)

    `NPD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy && !o_valid)

endmodule

bind nearest_prototype_distance npd_checker u_npd_checker (.*);
